// ===== sv/bfsa_pkg.sv =====
// ============================================================================
// Best-fit segment allocator package
// Shared widths, codes, table entry layout and controller/datapath links.
// ============================================================================
package bfsa_pkg;

	localparam int ADDR_W           = 48;
	localparam int LEN_W            = 40;
	localparam int CMD_W            = 2;
	localparam int STAT_W           = 2;
	localparam int MAX_SEGMENTS_DEF = 64;

	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REBUILD = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;
	localparam logic [STAT_W-1:0] ST_ZERO    = 2'd3;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef struct packed {
		logic [ADDR_W-1:0] base;
		logic [LEN_W-1:0]  len;
		logic              free;
	} seg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_REBUILD,
		OP_SCAN,
		OP_PREP,
		OP_SHIFT_UP,
		OP_WR_REM,
		OP_WR_BEST,
		OP_RD_NEXT,
		OP_GET_NEXT,
		OP_SUM1,
		OP_SUM2,
		OP_FREE_WR,
		OP_SHIFT_DN,
		OP_DROP
	} dp_op_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             req_zero;
		logic             size_ovf;
		logic             walk_done;
		logic             up_done;
		logic             found;
		logic             split;
		logic             ent_free;
	} dp_stat_t;

endpackage

// ===== sv/bfsa_ram.sv =====
// ============================================================================
// Segment table memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module bfsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/bfsa_dp.sv =====
// ============================================================================
// Best-fit allocator datapath
// Holds the segment table, the walk pointer, configuration and the search
// results, and performs one table operation per cycle as commanded.
// ============================================================================
module bfsa_dp #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_index,
	input  logic [bfsa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic [bfsa_pkg::CMD_W-1:0]    cmd,
	input  logic [bfsa_pkg::LEN_W-1:0]    req_size,
	input  logic [bfsa_pkg::ADDR_W-1:0]   free_addr,
	input  bfsa_pkg::dp_op_t              op,
	output bfsa_pkg::dp_stat_t            stat
);

	localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW = $clog2(MAX_SEGMENTS + 1);
	localparam int LW = bfsa_pkg::LEN_W;
	localparam int AW = bfsa_pkg::ADDR_W;

	logic [AW-1:0]              base_address_q;
	logic [LW-1:0]              area_size_q;
	logic [bfsa_pkg::CMD_W-1:0] cmd_q;
	logic                       zero_q;
	logic                       ovf_q;
	logic [LW-1:0]              size_q;
	logic [AW-1:0]              addr_q;
	logic [CW-1:0]              ptr_q;
	logic [CW-1:0]              count_q;
	logic                       rv_s1;
	logic [IW-1:0]              ridx_s1;
	logic                       found_q;
	logic [IW-1:0]              idx_q;
	bfsa_pkg::seg_t             ent_q;
	bfsa_pkg::seg_t             prv_q;
	logic [LW-1:0]              nlen_q;
	logic                       mnext_q;
	logic [LW-1:0]              acc_q;
	logic [LW-1:0]              rem_q;
	logic                       split_q;

	logic                       re;
	logic [IW-1:0]              raddr;
	logic                       we;
	logic [IW-1:0]              waddr;
	bfsa_pkg::seg_t             wdata;
	bfsa_pkg::seg_t             rdata;
	logic [LW:0]                rnd;
	logic [LW-1:0]              rem;
	logic [CW-1:0]              idx_nxt;
	logic                       has_next;
	logic                       mprev;
	logic [1:0]                 kk;
	logic [CW-1:0]              kk_ext;
	logic [CW-1:0]              drop_start;

	bfsa_ram #(
		.WIDTH($bits(bfsa_pkg::seg_t)),
		.DEPTH(MAX_SEGMENTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Request rounded up to a multiple of 8, one bit wider to catch overflow.
	assign rnd        = ({1'b0, req_size} + (LW+1)'(7)) & ~(LW+1)'(7);
	assign rem        = ent_q.len - size_q;
	assign idx_nxt    = CW'(idx_q) + CW'(1);
	assign has_next   = idx_nxt < count_q;
	assign mprev      = (idx_q != '0) && prv_q.free;
	assign kk         = {1'b0, mprev} + {1'b0, mnext_q};
	assign kk_ext     = CW'(kk);
	assign drop_start = mprev ? CW'(idx_q) : idx_nxt;

	always_comb begin
		re    = 1'b0;
		raddr = ptr_q[IW-1:0];
		we    = 1'b0;
		waddr = idx_q;
		wdata = ent_q;
		case (op)
			bfsa_pkg::OP_REBUILD: begin
				we    = 1'b1;
				waddr = '0;
				wdata = '{base: base_address_q, len: area_size_q, free: 1'b1};
			end
			bfsa_pkg::OP_SCAN: begin
				re = ptr_q < count_q;
			end
			bfsa_pkg::OP_SHIFT_UP: begin
				re    = ptr_q > idx_nxt;
				raddr = IW'(ptr_q - CW'(1));
				we    = rv_s1;
				waddr = ridx_s1 + IW'(1);
				wdata = rdata;
			end
			bfsa_pkg::OP_WR_REM: begin
				we    = 1'b1;
				waddr = idx_nxt[IW-1:0];
				wdata = '{base: ent_q.base + AW'(size_q), len: rem_q, free: 1'b1};
			end
			bfsa_pkg::OP_WR_BEST: begin
				we    = 1'b1;
				wdata = '{base: ent_q.base, len: (split_q ? size_q : ent_q.len),
					free: 1'b0};
			end
			bfsa_pkg::OP_RD_NEXT: begin
				re    = has_next;
				raddr = idx_nxt[IW-1:0];
			end
			bfsa_pkg::OP_FREE_WR: begin
				we = 1'b1;
				if (mprev) begin
					waddr = idx_q - IW'(1);
					wdata = '{base: prv_q.base, len: acc_q, free: 1'b1};
				end else begin
					wdata = '{base: ent_q.base, len: acc_q, free: 1'b1};
				end
			end
			bfsa_pkg::OP_SHIFT_DN: begin
				re    = ptr_q < count_q;
				we    = rv_s1;
				waddr = ridx_s1 - IW'(kk);
				wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_address_q <= '0;
			area_size_q    <= '0;
			count_q        <= CW'(1);
			ptr_q          <= '0;
			rv_s1          <= 1'b0;
			found_q        <= 1'b0;
		end else begin
			rv_s1 <= re;
			if (cfg_valid) begin
				if (cfg_index == bfsa_pkg::REG_BASE) begin
					base_address_q <= cfg_data;
				end else begin
					area_size_q <= cfg_data[LW-1:0];
				end
			end
			case (op)
				bfsa_pkg::OP_LOAD: begin
					ptr_q   <= '0;
					found_q <= 1'b0;
				end
				bfsa_pkg::OP_REBUILD: begin
					count_q <= CW'(1);
				end
				bfsa_pkg::OP_SCAN: begin
					if (re) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (rv_s1) begin
						if (cmd_q == bfsa_pkg::CMD_ALLOC) begin
							if (rdata.free && rdata.len >= size_q &&
								(!found_q || rdata.len < ent_q.len)) begin
								found_q <= 1'b1;
							end
						end else if (!found_q && rdata.base == addr_q) begin
							found_q <= 1'b1;
						end
					end
				end
				bfsa_pkg::OP_PREP: begin
					ptr_q <= count_q;
				end
				bfsa_pkg::OP_SHIFT_UP: begin
					if (re) begin
						ptr_q <= ptr_q - CW'(1);
					end
				end
				bfsa_pkg::OP_WR_REM: begin
					count_q <= count_q + CW'(1);
				end
				bfsa_pkg::OP_FREE_WR: begin
					ptr_q <= drop_start + kk_ext;
				end
				bfsa_pkg::OP_SHIFT_DN: begin
					if (re) begin
						ptr_q <= ptr_q + CW'(1);
					end
				end
				bfsa_pkg::OP_DROP: begin
					count_q <= count_q - kk_ext;
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		ridx_s1 <= raddr;
		case (op)
			bfsa_pkg::OP_LOAD: begin
				cmd_q           <= cmd;
				zero_q          <= req_size == '0;
				{ovf_q, size_q} <= rnd;
				addr_q          <= free_addr;
			end
			bfsa_pkg::OP_SCAN: begin
				if (rv_s1) begin
					if (cmd_q == bfsa_pkg::CMD_ALLOC) begin
						if (rdata.free && rdata.len >= size_q &&
							(!found_q || rdata.len < ent_q.len)) begin
							ent_q <= rdata;
							idx_q <= ridx_s1;
						end
					end else if (!found_q) begin
						if (rdata.base == addr_q) begin
							ent_q <= rdata;
							idx_q <= ridx_s1;
						end else begin
							prv_q <= rdata;
						end
					end
				end
			end
			bfsa_pkg::OP_PREP: begin
				rem_q   <= rem;
				split_q <= (rem >= (size_q >> 1)) && (count_q < CW'(MAX_SEGMENTS));
			end
			bfsa_pkg::OP_GET_NEXT: begin
				mnext_q <= has_next && rdata.free;
				nlen_q  <= rdata.len;
			end
			bfsa_pkg::OP_SUM1: begin
				acc_q <= ent_q.len + (mnext_q ? nlen_q : '0);
			end
			bfsa_pkg::OP_SUM2: begin
				if (mprev) begin
					acc_q <= acc_q + prv_q.len;
				end
			end
			default: begin
			end
		endcase
	end

	assign stat.cmd       = cmd_q;
	assign stat.req_zero  = zero_q;
	assign stat.size_ovf  = ovf_q;
	assign stat.walk_done = (ptr_q == count_q) && !rv_s1;
	assign stat.up_done   = (ptr_q == idx_nxt) && !rv_s1;
	assign stat.found     = found_q;
	assign stat.split     = split_q;
	assign stat.ent_free  = ent_q.free;

endmodule

// ===== sv/bfsa_ctrl.sv =====
// ============================================================================
// Best-fit allocator controller
// Sequences each command through the datapath and holds the result register.
// ============================================================================
module bfsa_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_stall,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic [bfsa_pkg::STAT_W-1:0]  status,
	output bfsa_pkg::dp_op_t             op,
	input  bfsa_pkg::dp_stat_t           stat
);

	typedef enum logic [4:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_REBUILD,
		S_SCAN_A,
		S_PREP,
		S_CHOOSE,
		S_SHIFT_UP,
		S_WR_REM,
		S_WR_BEST,
		S_SCAN_F,
		S_FCHECK,
		S_GETNEXT,
		S_SUM1,
		S_SUM2,
		S_FWR,
		S_SHIFT_DN,
		S_DROP,
		S_DONE
	} state_t;

	state_t                      state_q;
	logic [bfsa_pkg::STAT_W-1:0] pend_q;
	logic                        rsp_valid_q;
	logic [bfsa_pkg::STAT_W-1:0] status_q;

	assign cmd_stall = state_q != S_IDLE;
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;

	always_comb begin
		case (state_q)
			S_INIT:     op = bfsa_pkg::OP_REBUILD;
			S_IDLE:     op = cmd_valid ? bfsa_pkg::OP_LOAD : bfsa_pkg::OP_NONE;
			S_REBUILD:  op = bfsa_pkg::OP_REBUILD;
			S_SCAN_A:   op = bfsa_pkg::OP_SCAN;
			S_SCAN_F:   op = bfsa_pkg::OP_SCAN;
			S_PREP:     op = bfsa_pkg::OP_PREP;
			S_SHIFT_UP: op = bfsa_pkg::OP_SHIFT_UP;
			S_WR_REM:   op = bfsa_pkg::OP_WR_REM;
			S_WR_BEST:  op = bfsa_pkg::OP_WR_BEST;
			S_FCHECK:   op = bfsa_pkg::OP_RD_NEXT;
			S_GETNEXT:  op = bfsa_pkg::OP_GET_NEXT;
			S_SUM1:     op = bfsa_pkg::OP_SUM1;
			S_SUM2:     op = bfsa_pkg::OP_SUM2;
			S_FWR:      op = bfsa_pkg::OP_FREE_WR;
			S_SHIFT_DN: op = bfsa_pkg::OP_SHIFT_DN;
			S_DROP:     op = bfsa_pkg::OP_DROP;
			default:    op = bfsa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			pend_q      <= bfsa_pkg::ST_OK;
			rsp_valid_q <= 1'b0;
			status_q    <= bfsa_pkg::ST_OK;
		end else begin
			// A finished status loads the result register once it is free.
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
				status_q    <= pend_q;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (cmd_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (stat.cmd)
						bfsa_pkg::CMD_ALLOC: begin
							if (stat.req_zero) begin
								pend_q  <= bfsa_pkg::ST_ZERO;
								state_q <= S_DONE;
							end else if (stat.size_ovf) begin
								pend_q  <= bfsa_pkg::ST_NOFIT;
								state_q <= S_DONE;
							end else begin
								pend_q  <= bfsa_pkg::ST_OK;
								state_q <= S_SCAN_A;
							end
						end
						bfsa_pkg::CMD_FREE: begin
							pend_q  <= bfsa_pkg::ST_OK;
							state_q <= S_SCAN_F;
						end
						bfsa_pkg::CMD_REBUILD: begin
							pend_q  <= bfsa_pkg::ST_OK;
							state_q <= S_REBUILD;
						end
						default: begin
							pend_q  <= bfsa_pkg::ST_OK;
							state_q <= S_DONE;
						end
					endcase
				end
				S_REBUILD: begin
					state_q <= S_DONE;
				end
				S_SCAN_A: begin
					if (stat.walk_done) begin
						if (stat.found) begin
							state_q <= S_PREP;
						end else begin
							pend_q  <= bfsa_pkg::ST_NOFIT;
							state_q <= S_DONE;
						end
					end
				end
				S_PREP: begin
					state_q <= S_CHOOSE;
				end
				S_CHOOSE: begin
					state_q <= stat.split ? S_SHIFT_UP : S_WR_BEST;
				end
				S_SHIFT_UP: begin
					if (stat.up_done) begin
						state_q <= S_WR_REM;
					end
				end
				S_WR_REM: begin
					state_q <= S_WR_BEST;
				end
				S_WR_BEST: begin
					state_q <= S_DONE;
				end
				S_SCAN_F: begin
					if (stat.walk_done) begin
						state_q <= S_FCHECK;
					end
				end
				S_FCHECK: begin
					if (!stat.found || stat.ent_free) begin
						pend_q  <= bfsa_pkg::ST_BADADDR;
						state_q <= S_DONE;
					end else begin
						state_q <= S_GETNEXT;
					end
				end
				S_GETNEXT: begin
					state_q <= S_SUM1;
				end
				S_SUM1: begin
					state_q <= S_SUM2;
				end
				S_SUM2: begin
					state_q <= S_FWR;
				end
				S_FWR: begin
					state_q <= S_SHIFT_DN;
				end
				S_SHIFT_DN: begin
					if (stat.walk_done) begin
						state_q <= S_DROP;
					end
				end
				S_DROP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					// Hold the finished status until the result register is free.
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/best_fit_segment_allocator.sv =====
// ============================================================================
// Best-fit segment allocator
// Address-ordered segment table with best-fit allocate and coalescing free.
// ============================================================================
// One command is handled at a time. The segment table lives in a single
// memory with one read and one write port, and the allocate and free commands
// walk it one entry per cycle: an allocate scans the live segments and then
// moves entries up for a split, a free scans the segments and then moves
// entries down. After reset the block writes the initial free segment before
// it takes its first command. Configuration writes are always taken and only
// change the registers; a rebuild command applies them.
module best_fit_segment_allocator #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bfsa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [bfsa_pkg::CMD_W-1:0]    cmd,
	input  logic [bfsa_pkg::LEN_W-1:0]    req_size,
	input  logic [bfsa_pkg::ADDR_W-1:0]   free_addr,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bfsa_pkg::STAT_W-1:0]   status
);

	bfsa_pkg::dp_op_t   op;
	bfsa_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	bfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status   (status),
		.op       (op),
		.stat     (stat)
	);

	bfsa_dp #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.req_size (req_size),
		.free_addr(free_addr),
		.op       (op),
		.stat     (stat)
	);

	// A transfer in starts work, so the block must be busy right after it.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command accepted while block was not left busy");

	// A new result only appears after the block has been busy.
	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(cmd_stall))
		else $error("result raised without work in progress");

endmodule

// ===== verif/bfsa_checker.sv =====
// ============================================================================
// Best-fit segment allocator checker
// Watches the register, command and status channels, keeps its own copy of
// the segment table, predicts each status and compares it.
// ============================================================================
module bfsa_checker #(
	parameter int MAX_SEGMENTS = bfsa_pkg::MAX_SEGMENTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_index,
	input  logic [bfsa_pkg::ADDR_W-1:0]   cfg_data,
	input  logic                          cmd_valid,
	input  logic                          cmd_stall,
	input  logic [bfsa_pkg::CMD_W-1:0]    cmd,
	input  logic [bfsa_pkg::LEN_W-1:0]    req_size,
	input  logic [bfsa_pkg::ADDR_W-1:0]   free_addr,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [bfsa_pkg::STAT_W-1:0]   status,
	output int                            fails,
	output int                            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW = bfsa_pkg::ADDR_W;
	localparam int LW = bfsa_pkg::LEN_W;
	localparam int SW = bfsa_pkg::STAT_W;

	logic [AW-1:0] area_base;
	logic [LW-1:0] area_len;
	logic [AW-1:0] seg_base [MAX_SEGMENTS];
	logic [LW-1:0] seg_len  [MAX_SEGMENTS];
	bit            seg_free [MAX_SEGMENTS];
	int            seg_cnt;
	logic [SW-1:0] expected_status [$];

	assign pending = expected_status.size();

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		fails++;
	endtask

	function automatic void rebuild_area();
		for (int i = 0; i < MAX_SEGMENTS; i++) begin
			seg_base[i] = '0;
			seg_len[i] = '0;
			seg_free[i] = 0;
		end
		seg_base[0] = area_base;
		seg_len[0] = area_len;
		seg_free[0] = 1;
		seg_cnt = 1;
	endfunction

	function automatic void remove_segment(input int pos);
		for (int i = pos; i + 1 < seg_cnt; i++) begin
			seg_base[i] = seg_base[i+1];
			seg_len[i] = seg_len[i+1];
			seg_free[i] = seg_free[i+1];
		end
		seg_cnt--;
		seg_base[seg_cnt] = '0;
		seg_len[seg_cnt] = '0;
		seg_free[seg_cnt] = 0;
	endfunction

	function automatic logic [SW-1:0] allocate_segment(input logic [LW-1:0] req);
		logic [LW:0]   need;
		logic [LW-1:0] rest;
		int            best;
		if (req == '0)
			return bfsa_pkg::ST_ZERO;
		// Rounding is one bit wider so that an all-ones request fits nothing.
		need = ({1'b0, req} + 41'd7) & ~41'd7;
		best = -1;
		for (int i = 0; i < seg_cnt; i++) begin
			if (seg_free[i] && {1'b0, seg_len[i]} >= need) begin
				if (best < 0 || seg_len[i] < seg_len[best])
					best = i;
			end
		end
		if (best < 0)
			return bfsa_pkg::ST_NOFIT;
		rest = seg_len[best] - need[LW-1:0];
		if ({1'b0, rest} >= (need >> 1) && seg_cnt < MAX_SEGMENTS) begin
			for (int i = seg_cnt; i > best + 1; i--) begin
				seg_base[i] = seg_base[i-1];
				seg_len[i] = seg_len[i-1];
				seg_free[i] = seg_free[i-1];
			end
			seg_cnt++;
			seg_base[best+1] = seg_base[best] + AW'(need);
			seg_len[best+1] = rest;
			seg_free[best+1] = 1;
			seg_len[best] = need[LW-1:0];
		end
		seg_free[best] = 0;
		return bfsa_pkg::ST_OK;
	endfunction

	function automatic logic [SW-1:0] release_segment(input logic [AW-1:0] addr);
		int pos;
		pos = -1;
		for (int i = 0; i < seg_cnt; i++) begin
			if (pos < 0 && seg_base[i] == addr)
				pos = i;
		end
		if (pos < 0 || seg_free[pos])
			return bfsa_pkg::ST_BADADDR;
		seg_free[pos] = 1;
		if (pos + 1 < seg_cnt && seg_free[pos+1]) begin
			seg_len[pos] = seg_len[pos] + seg_len[pos+1];
			remove_segment(pos + 1);
		end
		if (pos > 0 && seg_free[pos-1]) begin
			seg_len[pos-1] = seg_len[pos-1] + seg_len[pos];
			remove_segment(pos);
		end
		return bfsa_pkg::ST_OK;
	endfunction

	// Base of a random allocated segment, so that most frees hit something.
	function automatic logic [AW-1:0] used_base();
		int idx [$];
		for (int i = 0; i < seg_cnt; i++) begin
			if (!seg_free[i])
				idx.push_back(i);
		end
		if (idx.size() == 0)
			return AW'({$urandom, $urandom});
		return seg_base[idx[$urandom_range(0, idx.size() - 1)]];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [SW-1:0] st;
		if (!arst_n) begin
			area_base = '0;
			area_len = '0;
			rebuild_area();
			expected_status.delete();
			fails = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bfsa_pkg::REG_BASE)
					area_base = cfg_data;
				else
					area_len = cfg_data[LW-1:0];
			end
			if (cmd_valid && !cmd_stall) begin
				st = bfsa_pkg::ST_OK;
				case (cmd)
					bfsa_pkg::CMD_ALLOC: st = allocate_segment(req_size);
					bfsa_pkg::CMD_FREE: st = release_segment(free_addr);
					bfsa_pkg::CMD_REBUILD: rebuild_area();
					default: st = bfsa_pkg::ST_OK;
				endcase
				expected_status.push_back(st);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_status.size() == 0) begin
					report_mismatch($sformatf("status %0d with no command outstanding", status));
				end else begin
					st = expected_status.pop_front();
					if (status !== st)
						report_mismatch($sformatf("status %0d, predicted %0d", status, st));
				end
			end
		end
	end

endmodule

// ===== verif/testbench.sv =====
// ============================================================================
// Best-fit segment allocator testbench
// Drives directed and random command streams over several area settings,
// with bursty input and a stalling receiver; the checker grades each status.
// ============================================================================
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                         AW = bfsa_pkg::ADDR_W;
	localparam int                         LW = bfsa_pkg::LEN_W;
	localparam int                         MAX_SEGMENTS = 64;
	localparam logic [bfsa_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int                         CYCLE_LIMIT = 1000000;
	localparam int                         SETTLE_CYCLES = 2 * MAX_SEGMENTS + 20;

	logic                          clk = 0;
	logic                          arst_n = 0;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic                          cfg_index;
	logic [AW-1:0]                 cfg_data;
	logic                          cmd_valid;
	logic                          cmd_stall;
	logic [bfsa_pkg::CMD_W-1:0]    cmd;
	logic [LW-1:0]                 req_size;
	logic [AW-1:0]                 free_addr;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [bfsa_pkg::STAT_W-1:0]   status;
	int                            fails;
	int                            pending;
	int                            cycles = 0;
	int                            burst_left = 0;
	bit                            hold_pending = 0;

	best_fit_segment_allocator #(.MAX_SEGMENTS(MAX_SEGMENTS)) DUT (.*);

	bfsa_checker #(.MAX_SEGMENTS(MAX_SEGMENTS)) chk (.*);

	always #5 clk = ~clk;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Receiver stalls in stretches: none, random, or mostly stalled. On request
	// it holds off for a long run so the block backs up into its input.
	initial begin
		int n;
		int mode;
		bit held;
		held = 0;
		rsp_stall = 0;
		@(posedge clk);
		forever begin
			if (hold_pending && !held) begin
				held = 1;
				rsp_stall <= 1;
				repeat (400) @(posedge clk);
			end
			mode = $urandom_range(0, 2);
			n = $urandom_range(1, 40);
			repeat (n) begin
				case (mode)
					0: rsp_stall <= 0;
					1: rsp_stall <= 1'($urandom_range(0, 1));
					default: rsp_stall <= ($urandom_range(0, 3) != 0);
				endcase
				@(posedge clk);
			end
		end
	end

	task automatic issue(input logic [bfsa_pkg::CMD_W-1:0] c, input logic [LW-1:0] r,
			input logic [AW-1:0] a);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				cmd_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		cmd_valid <= 1;
		cmd <= c;
		req_size <= r;
		free_addr <= a;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
	endtask

	task automatic drain();
		cmd_valid <= 0;
		burst_left = 0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// Leaves valid high; the caller lowers it after its last write.
	task automatic write_reg(input logic idx, input logic [AW-1:0] value);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// Loads a new area while nothing is in flight and rebuilds the table.
	task automatic set_area(input logic [AW-1:0] b, input logic [LW-1:0] len);
		drain();
		if ($urandom_range(0, 1)) begin
			write_reg(bfsa_pkg::REG_BASE, b);
			write_reg(bfsa_pkg::REG_SIZE, {8'(~len[7:0]), len});
		end else begin
			write_reg(bfsa_pkg::REG_SIZE, {8'(~len[7:0]), len});
			write_reg(bfsa_pkg::REG_BASE, b);
		end
		cfg_valid <= 0;
		issue(bfsa_pkg::CMD_REBUILD, LW'({$urandom, $urandom}), AW'({$urandom, $urandom}));
	endtask

	task automatic random_item(input int unsigned max_req);
		int            sel;
		logic [LW-1:0] r;
		logic [AW-1:0] a;
		sel = $urandom_range(0, 99);
		r = LW'({$urandom, $urandom});
		a = AW'({$urandom, $urandom});
		if (sel < 50) begin
			if ($urandom_range(0, 9) != 0)
				r = LW'($urandom_range(1, max_req));
			issue(bfsa_pkg::CMD_ALLOC, r, a);
		end else if (sel < 82)
			issue(bfsa_pkg::CMD_FREE, r, chk.used_base());
		else if (sel < 88)
			issue(bfsa_pkg::CMD_FREE, r, a);
		else if (sel < 91)
			issue(bfsa_pkg::CMD_REBUILD, r, a);
		else if (sel < 95)
			issue(CMD_UNUSED, r, a);
		else
			issue(bfsa_pkg::CMD_ALLOC, '0, a);
	endtask

	initial begin
		logic [AW-1:0] p_base [6];
		logic [LW-1:0] p_len  [6];
		int unsigned   p_req  [6];
		int            p_items [6];
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = '0;
		cmd_valid = 0;
		cmd = bfsa_pkg::CMD_ALLOC;
		req_size = '0;
		free_addr = '0;
		wait (arst_n);
		@(posedge clk);

		// Area at the top of the address space, so a split remainder wraps to 0.
		set_area(48'hFFFF_FFFF_FFF8, 40'd1024);
		issue(bfsa_pkg::CMD_ALLOC, '0, '1);
		issue(bfsa_pkg::CMD_ALLOC, '1, '0);
		issue(CMD_UNUSED, '1, '1);
		issue(bfsa_pkg::CMD_ALLOC, 40'd1, '0);
		issue(bfsa_pkg::CMD_FREE, '0, '1);
		issue(bfsa_pkg::CMD_FREE, '0, 48'hFFFF_FFFF_FFF8);
		issue(bfsa_pkg::CMD_FREE, '0, 48'hFFFF_FFFF_FFF8);
		issue(bfsa_pkg::CMD_ALLOC, 40'd8, '0);
		issue(bfsa_pkg::CMD_ALLOC, 40'd500, '0);
		issue(bfsa_pkg::CMD_ALLOC, 40'd1016, '0);
		issue(bfsa_pkg::CMD_FREE, '0, 48'h0);
		issue(bfsa_pkg::CMD_FREE, '0, 48'h8);
		issue(bfsa_pkg::CMD_ALLOC, 40'd1017, '0);
		issue(bfsa_pkg::CMD_ALLOC, 40'd1016, '0);
		set_area('1, '1);
		issue(bfsa_pkg::CMD_ALLOC, 40'hFF_FFFF_FFF8, '0);
		issue(bfsa_pkg::CMD_FREE, '0, '1);
		set_area('0, '0);
		issue(bfsa_pkg::CMD_ALLOC, 40'd1, '0);
		issue(bfsa_pkg::CMD_FREE, '0, '0);

		// Small area with tiny requests fills the segment table.
		p_base[0] = AW'({$urandom, $urandom}); p_len[0] = 40'd600; p_req[0] = 16;
		p_items[0] = 120;
		p_base[1] = '0;  p_len[1] = '0;                         p_req[1] = 64;   p_items[1] = 30;
		p_base[2] = 48'hFFFF_FFFF_FC00;   p_len[2] = 40'd4096;  p_req[2] = 256;  p_items[2] = 120;
		p_base[3] = AW'({$urandom, $urandom}); p_len[3] = '1; p_req[3] = 32'hFFFF_FFFF;
		p_items[3] = 110;
		p_base[4] = '0;  p_len[4] = 40'd65536;                  p_req[4] = 2048; p_items[4] = 120;
		p_base[5] = AW'({$urandom, $urandom}); p_len[5] = LW'({$urandom, $urandom});
		p_req[5] = 32'h0100_0000; p_items[5] = 110;

		for (int ph = 0; ph < 6; ph++) begin
			set_area(p_base[ph], p_len[ph]);
			for (int k = 0; k < p_items[ph]; k++) begin
				if (ph == 2 && k == 20)
					hold_pending = 1;
				random_item(p_req[ph]);
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending != 0)
			chk.report_mismatch($sformatf("%0d statuses never arrived", pending));
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== best_fit_segment_allocator.f =====
sv/bfsa_pkg.sv
sv/bfsa_ram.sv
sv/bfsa_dp.sv
sv/bfsa_ctrl.sv
sv/best_fit_segment_allocator.sv
verif/bfsa_checker.sv
verif/testbench.sv
